[rtl/alpha_premultiply_convert_core_macros.svh]
// assertion helpers shared by the rtl
`ifndef ALPHA_PREMULTIPLY_CONVERT_CORE_MACROS_SVH
`define ALPHA_PREMULTIPLY_CONVERT_CORE_MACROS_SVH

// implication checked outside reset
`define APC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apc assertion failed");

// next-cycle implication, also checked across reset
`define APC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("apc assertion failed");

`endif

[rtl/apc_pkg.sv]
package apc_pkg;

  localparam int PIX_W         = 8;
  localparam int NUM_W         = 2 * PIX_W;
  localparam int NUM_LANES     = 3;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STAGES    = PIX_W / BITS_PER_STEP;
  localparam int RND_W         = PIX_W - 1;

  localparam logic [PIX_W-1:0] PIX_MAX  = {PIX_W{1'b1}};
  localparam logic [RND_W-1:0] PM_ROUND = {RND_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_UNPREMUL = 2'd0,
    FUNC_PREMUL   = 2'd1,
    FUNC_GREY     = 2'd2,
    FUNC_BYPASS   = 2'd3
  } func_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NUM_W-1:0] num_t;

  typedef struct packed {
    num_t rem;
    pix_t quo;
  } div_state_t;

  // restoring division, BITS_PER_STEP quotient bits from the top down
  function automatic div_state_t div_steps(input num_t rem, input pix_t quo,
                                           input pix_t den, input int unsigned stage);
    div_state_t st;
    num_t       dsh;
    logic [2:0] pos;
    st.rem = rem;
    st.quo = quo;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      pos = 3'(PIX_W - 1 - int'(stage) * BITS_PER_STEP - b);
      dsh = num_t'(den) << pos;
      if (st.rem >= dsh) begin
        st.rem = st.rem - dsh;
        st.quo[pos] = 1'b1;
      end
    end
    return st;
  endfunction

endpackage

[rtl/alpha_premultiply_convert_core.sv]
// throughput: one pixel per clock; a stall at m_tready backs up the five-stage
// pipeline (one multiply stage, four stages of two-bit restoring division per lane)
// reset: rst synchronous, active high, clears every stage valid bit; payload
// registers are not reset
module alpha_premultiply_convert_core
  import apc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [NUM_LANES*PIX_W+PIX_W-1:0] s_tdata,  // in_red, in_green, in_blue, in_alpha
  input  logic [1:0]                    s_tuser,  // func
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [NUM_LANES*PIX_W+PIX_W-1:0] m_tdata   // out_red, out_green, out_blue, out_alpha
);

  `include "alpha_premultiply_convert_core_macros.svh"

  localparam int LAST = DIV_STAGES;

  logic [LAST:0] vld;
  logic [LAST:0] adv;

  num_t rem   [0:LAST-1][0:NUM_LANES-1];
  pix_t quo   [1:LAST-1][0:NUM_LANES-1];
  logic ovf   [1:LAST-1][0:NUM_LANES-1];
  pix_t chan  [0:LAST-1][0:NUM_LANES-1];
  pix_t den   [0:LAST-1];
  logic pass  [0:LAST-1];
  pix_t alpha [0:LAST];
  pix_t res   [0:NUM_LANES-1];

  // stage 0 inputs
  func_t fn;
  pix_t  a_in;
  pix_t  mul_m;
  pix_t  den_in;
  logic [RND_W-1:0] rnd;
  logic  pass_in;
  pix_t  c_in   [0:NUM_LANES-1];
  num_t  num_in [0:NUM_LANES-1];

  div_state_t nx   [1:LAST][0:NUM_LANES-1];
  logic       ovf1 [0:NUM_LANES-1];

  // backpressure: a stage moves when it is empty or the next one moves
  always_comb begin
    adv[LAST] = !vld[LAST] || m_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[LAST];

  always_comb begin
    fn   = func_t'(s_tuser);
    a_in = s_tdata[NUM_LANES*PIX_W +: PIX_W];
    unique case (fn)
      FUNC_UNPREMUL: begin
        mul_m   = PIX_MAX;
        rnd     = RND_W'(a_in >> 1);
        den_in  = a_in;
        pass_in = (a_in == '0) || (a_in == PIX_MAX);
      end
      FUNC_PREMUL, FUNC_GREY: begin
        mul_m   = a_in;
        rnd     = PM_ROUND;
        den_in  = PIX_MAX;
        pass_in = (a_in == PIX_MAX);
      end
      FUNC_BYPASS: begin
        mul_m   = a_in;
        rnd     = PM_ROUND;
        den_in  = PIX_MAX;
        pass_in = 1'b1;
      end
      default: begin
        mul_m   = a_in;
        rnd     = PM_ROUND;
        den_in  = PIX_MAX;
        pass_in = 1'b1;
      end
    endcase
    for (int l = 0; l < NUM_LANES; l++) begin
      // grey copies the red channel into every lane
      c_in[l]   = (fn == FUNC_GREY) ? s_tdata[PIX_W-1:0] : s_tdata[l*PIX_W +: PIX_W];
      num_in[l] = num_t'(c_in[l]) * num_t'(mul_m) + num_t'(rnd);
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      nx[1][l] = div_steps(rem[0][l], '0, den[0], 0);
      // quotient above 255 means saturate
      ovf1[l]  = rem[0][l] >= (num_t'(den[0]) << PIX_W);
      for (int k = 2; k <= LAST; k++) begin
        nx[k][l] = div_steps(rem[k-1][l], quo[k-1][l], den[k-1], k - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      den[0]   <= den_in;
      pass[0]  <= pass_in;
      alpha[0] <= a_in;
      for (int l = 0; l < NUM_LANES; l++) begin
        rem[0][l]  <= num_in[l];
        chan[0][l] <= c_in[l];
      end
    end
    if (adv[1]) begin
      den[1]   <= den[0];
      pass[1]  <= pass[0];
      alpha[1] <= alpha[0];
      for (int l = 0; l < NUM_LANES; l++) begin
        rem[1][l]  <= nx[1][l].rem;
        quo[1][l]  <= nx[1][l].quo;
        ovf[1][l]  <= ovf1[l];
        chan[1][l] <= chan[0][l];
      end
    end
    for (int k = 2; k < LAST; k++) begin
      if (adv[k]) begin
        den[k]   <= den[k-1];
        pass[k]  <= pass[k-1];
        alpha[k] <= alpha[k-1];
        for (int l = 0; l < NUM_LANES; l++) begin
          rem[k][l]  <= nx[k][l].rem;
          quo[k][l]  <= nx[k][l].quo;
          ovf[k][l]  <= ovf[k-1][l];
          chan[k][l] <= chan[k-1][l];
        end
      end
    end
    if (adv[LAST]) begin
      alpha[LAST] <= alpha[LAST-1];
      for (int l = 0; l < NUM_LANES; l++) begin
        if (pass[LAST-1]) begin
          res[l] <= chan[LAST-1][l];
        end else if (ovf[LAST-1][l]) begin
          res[l] <= PIX_MAX;
        end else begin
          res[l] <= nx[LAST][l].quo;
        end
      end
    end
  end

  assign m_tdata = {alpha[LAST], res[2], res[1], res[0]};

  `APC_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid)
  `APC_ASSERT_IMPL(a_empty_out_ready, !m_tvalid, s_tready)
  `APC_ASSERT_IMPL(a_full_stall_blocks, (&vld) && !m_tready, !s_tready)

endmodule
